// ----- hdl/lpf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpf_pkg: shared types and constants
// Request and result structs, opcodes, status codes and the default register
// values for the linear preference flow block.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int unsigned TableDepthDefault = 4096;

  localparam logic [30:0] PrefThresholdReset   = 31'd65536;
  localparam logic [16:0] CriterionWeightReset = 17'd65536;
  localparam logic [16:0] WeightOne            = 17'd65536;

  localparam logic [0:0] RegPrefThreshold   = 1'b0;
  localparam logic [0:0] RegCriterionWeight = 1'b1;

  typedef enum logic [1:0] {
    FuncClear  = 2'd0,
    FuncAppend = 2'd1,
    FuncQuery  = 2'd2,
    FuncNone   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusOrder    = 2'd2,
    StatusInvalid  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [30:0]        entry_value;
    logic [23:0]        entry_count;
    logic signed [31:0] query_value;
    logic               query_is_nan;
    logic signed [63:0] prior_flow;
    logic               prior_invalid;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] positive_flow;
    logic signed [63:0] negative_flow;
    logic signed [63:0] accumulated_flow;
    logic               flow_invalid;
  } rsp_t;

endpackage

// ----- hdl/lpf_div.sv -----
// ----------------------------------------------------------------------------
// lpf_div: serial restoring divider
// Floor of a 96-bit dividend over a 31-bit divisor, one quotient bit per
// cycle. Quotient saturates to the largest positive signed 64-bit value.
// ----------------------------------------------------------------------------
module lpf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [95:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        busy_o,
  output logic [62:0] quot_o
);

  logic [95:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [95:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [31:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[30:0], num_q[95]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 7'd96;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[94:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[94:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[94:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quot_o = (quo_q[95:63] != '0) ? {63{1'b1}} : quo_q[62:0];

endmodule

// ----- hdl/linear_preference_flow.sv -----
// ----------------------------------------------------------------------------
// linear_preference_flow: PROMETHEE II linear preference flow unit
// Builds an ascending value table with running counts and value sums, and
// answers pixel queries with positive, negative and accumulated flows.
// ----------------------------------------------------------------------------
// Sequence: clear and append finish through the output state; a query runs
//   binary searches, cumulative reads and up to two serial divisions.
// Throughput: one request at a time; the next is taken once the result leaves
//   the output register. Rate is set by the serial divider and binary search.
// Reset: asynchronous, active low; table empty, registers at defaults. Table
//   memories are not cleared; only entries below the fill count are read.
// ----------------------------------------------------------------------------
module linear_preference_flow #(
  parameter int unsigned TableDepth = lpf_pkg::TableDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [30:0]   cfg_data_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  lpf_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lpf_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;

  // Sequencer, one-hot
  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StApRd   = 15'b000000000000010,
    StApWr   = 15'b000000000000100,
    StSrch   = 15'b000000000001000,
    StSrchW  = 15'b000000000010000,
    StCumRd  = 15'b000000000100000,
    StCumW   = 15'b000000001000000,
    StMulA   = 15'b000000010000000,
    StMulB   = 15'b000000100000000,
    StMulC   = 15'b000001000000000,
    StDivGo  = 15'b000010000000000,
    StDivW   = 15'b000100000000000,
    StAcc    = 15'b001000000000000,
    StFin    = 15'b010000000000000,
    StOut    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [30:0] pref_q;
  logic [16:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q   <= lpf_pkg::PrefThresholdReset;
      weight_q <= lpf_pkg::CriterionWeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpf_pkg::RegPrefThreshold:   pref_q   <= cfg_data_i;
        lpf_pkg::RegCriterionWeight: weight_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // table memories, one read port shared over phases
  logic [30:0] mem_val [TableDepth];
  logic [31:0] mem_cnt [TableDepth];
  logic [63:0] mem_sum [TableDepth];
  logic [AW-1:0] rd_addr;
  logic [30:0] rd_val_q;
  logic [31:0] rd_cnt_q;
  logic [63:0] rd_sum_q;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [30:0] wr_val;
  logic [31:0] wr_cnt;
  logic [63:0] wr_sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_val[wr_addr] <= wr_val;
      mem_cnt[wr_addr] <= wr_cnt;
      mem_sum[wr_addr] <= wr_sum;
    end
    rd_val_q <= mem_val[rd_addr];
    rd_cnt_q <= mem_cnt[rd_addr];
    rd_sum_q <= mem_sum[rd_addr];
  end

  // working registers
  lpf_pkg::req_t req_q;
  lpf_pkg::rsp_t rsp_q;
  logic          rsp_valid_q;
  logic [CW-1:0] used_q;
  logic [CW-1:0] lo_q, hi_q;
  logic [1:0]    pass_q;       // 0..3: a2 pos, a1 pos, a2 neg, a1 neg
  logic signed [33:0] key_q;   // search key
  logic [CW-1:0] a2_q;
  logic [31:0]   c_a2_q, c_a1_q, c_tot_q;
  logic [63:0]   s_a2_q, s_a1_q;
  logic [63:0]   prod_q;       // partial product register
  logic [63:0]   d_q;
  logic [63:0]   base_q;       // weight * count term
  logic [63:0]   pos_q, neg_q;
  logic          side_q;       // 0 positive, 1 negative
  logic          cumsel_q;     // which cumulative read

  // result contents loaded at acceptance: initial status and the early-out fields
  lpf_pkg::rsp_t rsp_start;
  always_comb begin
    rsp_start = '0;
    case (lpf_pkg::func_e'(req_i.func))
      lpf_pkg::FuncAppend: begin
        if (used_q >= CW'(TableDepth)) rsp_start.status = lpf_pkg::StatusFull;
      end
      lpf_pkg::FuncQuery: begin
        if (req_i.query_is_nan || req_i.query_value[31]) begin
          rsp_start.status           = lpf_pkg::StatusInvalid;
          rsp_start.accumulated_flow = req_i.prior_flow;
          rsp_start.flow_invalid     = 1'b1;
        end else rsp_start.flow_invalid = req_i.prior_invalid;
      end
      default: ;
    endcase
  end

  logic [31:0] q_u;
  logic [31:0] p_u;
  logic [16:0] w_u;
  assign q_u = req_q.query_value;
  assign p_u = (pref_q == '0) ? 32'd1 : {1'b0, pref_q};
  assign w_u = (weight_q > lpf_pkg::WeightOne) ? lpf_pkg::WeightOne : weight_q;

  logic [CW-1:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // divider
  logic        div_start;
  logic        div_busy;
  logic [95:0] div_num_q;
  logic [62:0] div_quot;
  lpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num_q),
    .divisor_i  (p_u[30:0]),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // one shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [31:0] amount;
  assign amount = side_q ? (c_a2_q - c_a1_q) : (c_a1_q - c_a2_q);

  logic signed [33:0] key_next;
  always_comb begin
    case (pass_q)
      2'd0:    key_next = $signed({2'b0, q_u}) + 34'sd1;            // not used: the a1 pos key is q itself
      2'd1:    key_next = $signed({2'b0, q_u}) + $signed({2'b0, p_u}) + 34'sd1;
      default: key_next = $signed({2'b0, q_u}) + 34'sd1;            // a1 neg
    endcase
  end

  logic [63:0] sat_sum;
  logic [64:0] add_w;

  always_comb begin
    rd_addr = '0;
    if (state_q == StSrch) rd_addr = mid[AW-1:0];
    else if (state_q == StApRd) rd_addr = AW'(used_q - CW'(1));
    else if (state_q == StCumRd) begin
      case (cumsel_q)
        1'b0:    rd_addr = AW'(a2_q - CW'(1));
        default: rd_addr = AW'(lo_q - CW'(1));
      endcase
    end else if (state_q == StMulA) rd_addr = AW'(used_q - CW'(1));
  end

  assign wr_en   = (state_q == StApWr) &&
                   !(used_q != '0 && req_q.entry_value <= rd_val_q);
  assign wr_addr = used_q[AW-1:0];
  assign wr_val  = req_q.entry_value;
  assign wr_cnt  = ((used_q != '0) ? rd_cnt_q : 32'd0) + {8'd0, req_q.entry_count};
  assign wr_sum  = ((used_q != '0) ? rd_sum_q : 64'd0) + prod_q;

  always_comb begin
    mul_a = {1'b0, req_q.entry_value};
    mul_b = {8'd0, req_q.entry_count};
    case (state_q)
      StMulA: begin mul_a = amount; mul_b = q_u; end
      StMulB: begin mul_a = {15'd0, w_u}; mul_b = d_q[31:0]; end
      StMulC: begin mul_a = {15'd0, w_u}; mul_b = d_q[63:32]; end
      StAcc: begin
        mul_a = {15'd0, w_u};
        mul_b = side_q ? (c_tot_q - c_a2_q) : c_a2_q;
      end
      default: ;
    endcase
  end

  assign add_w   = {1'b0, base_q} + {2'b0, div_quot};
  assign sat_sum = (add_w > {1'b0, SMax}) ? SMax : add_w[63:0];

  logic signed [64:0] r1, r2;
  logic signed [63:0] r1s;
  assign r1  = $signed({req_q.prior_flow[63], req_q.prior_flow}) + $signed({1'b0, pos_q});
  assign r1s = (r1 > $signed({1'b0, SMax})) ? SMax : r1[63:0];
  assign r2  = $signed({r1s[63], r1s}) - $signed({1'b0, neg_q});

  assign div_start   = (state_q == StDivGo);
  assign req_ready_o = (state_q == StIdle) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (req_valid_i && req_ready_o) req_q <= req_i;
      StApRd: prod_q <= mul_p;
      StMulA: d_q <= side_q ? ((s_a2_q - s_a1_q) - mul_p) : (mul_p - (s_a1_q - s_a2_q));
      StMulB: prod_q <= mul_p;
      // full weight * distance product: high half shifted up, low half added
      StMulC: div_num_q <= ({32'd0, mul_p} << 32) + {32'd0, prod_q};
      StAcc:  base_q <= (side_q && a2_q >= used_q) ? 64'd0 : mul_p;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
      lo_q <= '0; hi_q <= '0; pass_q <= '0; side_q <= 1'b0; cumsel_q <= 1'b0;
      a2_q <= '0; key_q <= '0;
      c_a2_q <= '0; c_a1_q <= '0; c_tot_q <= '0; s_a2_q <= '0; s_a1_q <= '0;
      pos_q <= '0; neg_q <= '0; rsp_q <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (req_valid_i && req_ready_o) begin
          rsp_q <= rsp_start;
          case (lpf_pkg::func_e'(req_i.func))
            lpf_pkg::FuncClear: begin used_q <= '0; state_q <= StOut; end
            lpf_pkg::FuncAppend: begin
              if (used_q >= CW'(TableDepth)) state_q <= StOut;
              else state_q <= StApRd;
            end
            lpf_pkg::FuncQuery: begin
              if (req_i.query_is_nan || req_i.query_value[31]) begin
                state_q <= StOut;
              end else begin
                pass_q <= 2'd0;
                side_q <= 1'b0;
                lo_q   <= '0;
                hi_q   <= used_q;
                key_q  <= $signed({2'b0, req_i.query_value[31:0]})
                          - $signed({2'b0, ((pref_q == '0) ? 32'd1 : {1'b0, pref_q})});
                state_q <= StSrch;
              end
            end
            default: state_q <= StOut;
          endcase
        end
        StApRd: state_q <= StApWr;
        StApWr: begin
          if (wr_en) used_q <= used_q + CW'(1);
          else rsp_q.status <= lpf_pkg::StatusOrder;
          state_q <= StOut;
        end
        StSrch: begin
          if (lo_q >= hi_q) begin
            if (pass_q[0] == 1'b0) begin
              a2_q <= lo_q;
              pass_q <= pass_q + 2'd1;
              key_q <= (pass_q == 2'd0) ? $signed({2'b0, q_u}) : key_next;
              hi_q <= used_q;
              lo_q <= '0;
            end else begin
              cumsel_q <= 1'b0;
              state_q <= StCumRd;
            end
          end else state_q <= StSrchW;
        end
        StSrchW: begin
          if ($signed({3'b0, rd_val_q}) < key_q) lo_q <= mid + CW'(1);
          else hi_q <= mid;
          state_q <= StSrch;
        end
        StCumRd: state_q <= StCumW;
        StCumW: begin
          if (cumsel_q == 1'b0) begin
            c_a2_q <= (a2_q != '0) ? rd_cnt_q : 32'd0;
            s_a2_q <= (a2_q != '0) ? rd_sum_q : 64'd0;
            cumsel_q <= 1'b1;
            state_q <= StCumRd;
          end else begin
            c_a1_q <= (lo_q != '0) ? rd_cnt_q : 32'd0;
            s_a1_q <= (lo_q != '0) ? rd_sum_q : 64'd0;
            state_q <= StMulA;
          end
        end
        StMulA: state_q <= StMulB;
        StMulB: begin
          c_tot_q <= (used_q != '0) ? rd_cnt_q : 32'd0;
          state_q <= StMulC;
        end
        StMulC: state_q <= StAcc;
        StAcc:  state_q <= (amount != '0) ? StDivGo : StFin;
        StDivGo: state_q <= StDivW;
        StDivW: if (!div_busy) state_q <= StFin;
        StFin: begin
          if (!side_q) begin
            pos_q  <= (amount != '0) ? sat_sum : base_q;
            side_q <= 1'b1;
            pass_q <= 2'd2;
            lo_q   <= '0;
            hi_q   <= used_q;
            key_q  <= key_next;
            state_q <= StSrch;
          end else begin
            neg_q  <= (amount != '0) ? sat_sum : base_q;
            state_q <= StOut;
            side_q <= 1'b0;
          end
        end
        StOut: begin
          if (req_q.func == lpf_pkg::FuncQuery && rsp_q.status == lpf_pkg::StatusOk) begin
            rsp_q.positive_flow    <= pos_q;
            rsp_q.negative_flow    <= neg_q;
            rsp_q.accumulated_flow <= (r2 < $signed({1'b1, 64'h8000_0000_0000_0000}))
                                      ? 64'h8000_0000_0000_0000 : r2[63:0];
          end
          rsp_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
